[src/pbi_pkg.sv]
// Package for the bounded-integral PID core: field widths, register
// indexes and the structs passed between the core's modules.
// No dependencies.
package pbi_pkg;

    // Field widths fixed by the register map and the data path.
    localparam int GAIN_W   = 16;
    localparam int POS_W    = 24;
    localparam int ERR_W    = POS_W + 1;
    localparam int LIMIT_W  = 7;
    localparam int BAND_W   = 16;
    localparam int STEP_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int INTEG_W  = 32;
    localparam int DRIVE_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 7'd100;
    localparam logic [STEP_W-1:0]  STEP_LIMIT_RST  = 16'd256;
    localparam logic [COUNT_W-1:0] SETTLE_STEPS_RST = 8'd10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_SETPOINT     = 3'd3,
        REG_DRIVE_LIMIT  = 3'd4,
        REG_SETTLE_BAND  = 3'd5,
        REG_STEP_LIMIT   = 3'd6,
        REG_SETTLE_STEPS = 3'd7
    } cfg_index_t;

    // Current register contents.
    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic signed [POS_W-1:0]  setpoint;
        logic [LIMIT_W-1:0]       drive_limit;
        logic [BAND_W-1:0]        settle_band;
        logic [STEP_W-1:0]        integ_step_limit;
        logic [COUNT_W-1:0]       settle_steps;
    } cfg_t;

    // Result of the integral and band evaluation for one word.
    typedef struct packed {
        logic signed [INTEG_W-1:0] integ_sum;
        logic                      in_band;
    } integ_res_t;

endpackage

[src/pbi_cfg_regs.sv]
// Configuration register file of the bounded-integral PID core.
// Depends on pbi_pkg.
module pbi_cfg_regs
    import pbi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // Register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_PROP_GAIN:    cfg_next.prop_gain        = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:   cfg_next.integ_gain       = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   cfg_next.deriv_gain       = cfg_data[GAIN_W-1:0];
                REG_SETPOINT:     cfg_next.setpoint         = cfg_data[POS_W-1:0];
                REG_DRIVE_LIMIT:  cfg_next.drive_limit      = cfg_data[LIMIT_W-1:0];
                REG_SETTLE_BAND:  cfg_next.settle_band      = cfg_data[BAND_W-1:0];
                REG_STEP_LIMIT:   cfg_next.integ_step_limit = cfg_data[STEP_W-1:0];
                REG_SETTLE_STEPS: cfg_next.settle_steps     = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain        <= '0;
            cfg_reg.integ_gain       <= '0;
            cfg_reg.deriv_gain       <= '0;
            cfg_reg.setpoint         <= '0;
            cfg_reg.drive_limit      <= DRIVE_LIMIT_RST;
            cfg_reg.settle_band      <= '0;
            cfg_reg.integ_step_limit <= STEP_LIMIT_RST;
            cfg_reg.settle_steps     <= SETTLE_STEPS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/pbi_integ.sv]
// Integral update and on-target band check of the PID core.
// Depends on pbi_pkg.
module pbi_integ
    import pbi_pkg::*;
(
    input  logic signed [ERR_W-1:0]   err,
    input  logic signed [INTEG_W-1:0] integ_sum,
    input  logic [BAND_W-1:0]         settle_band,
    input  logic [STEP_W-1:0]         integ_step_limit,
    output integ_res_t                res
);

    localparam int WIDE_W = INTEG_W + 2;

    logic signed [ERR_W-1:0]  band_pos;
    logic signed [ERR_W-1:0]  band_neg;
    logic                     above;
    logic                     below;
    logic                     in_band;
    logic signed [WIDE_W-1:0] errq;
    logic signed [WIDE_W-1:0] lim;
    logic signed [WIDE_W-1:0] sum_wide;
    logic signed [WIDE_W-1:0] base;
    logic signed [WIDE_W-1:0] incr;
    logic signed [WIDE_W-1:0] total;
    logic signed [WIDE_W-1:0] max_sum;
    logic signed [WIDE_W-1:0] min_sum;

    // Band edges in whole units and the error in Q.8.
    assign band_pos = {{(ERR_W-BAND_W){1'b0}}, settle_band};
    assign band_neg = -band_pos;
    assign above    = (err >= band_pos);
    assign below    = (err <= band_neg);
    assign errq     = {{(WIDE_W-ERR_W-8){err[ERR_W-1]}}, err, 8'b0};
    assign lim      = {{(WIDE_W-STEP_W){1'b0}}, integ_step_limit};
    assign sum_wide = {{(WIDE_W-INTEG_W){integ_sum[INTEG_W-1]}}, integ_sum};

    assign max_sum = {{(WIDE_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
    assign min_sum = {{(WIDE_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

    // On target when the error lies within the band.
    assign in_band = (err <= band_pos) && (err >= band_neg);

    // A sign flip drops the opposite-signed sum; step limited; zero inside the band.
    always_comb
    begin
        base = '0;
        incr = '0;
        if (above)
        begin
            base = sum_wide[WIDE_W-1] ? '0 : sum_wide;
            incr = (errq < lim) ? errq : lim;
        end
        else if (below)
        begin
            base = (sum_wide > 0) ? '0 : sum_wide;
            incr = (errq > -lim) ? errq : -lim;
        end
        total = base + incr;
    end

    // Saturate to the signed 32 bit range.
    always_comb
    begin
        res.in_band = in_band;
        if (total > max_sum)
        begin
            res.integ_sum = max_sum[INTEG_W-1:0];
        end
        else if (total < min_sum)
        begin
            res.integ_sum = min_sum[INTEG_W-1:0];
        end
        else
        begin
            res.integ_sum = total[INTEG_W-1:0];
        end
    end

endmodule

[src/pbi_drive.sv]
// Drive computation of the PID core: three gain products, P + I - D in Q.16,
// the clamp to the drive limit and truncation toward zero. Depends on pbi_pkg.
module pbi_drive
    import pbi_pkg::*;
(
    input  logic signed [GAIN_W-1:0]  prop_gain,
    input  logic signed [GAIN_W-1:0]  integ_gain,
    input  logic signed [GAIN_W-1:0]  deriv_gain,
    input  logic [LIMIT_W-1:0]        drive_limit,
    input  logic signed [ERR_W-1:0]   err,
    input  logic signed [ERR_W-1:0]   vel,
    input  logic signed [INTEG_W-1:0] integ_sum,
    output logic signed [DRIVE_W-1:0] drive
);

    localparam int PD_W  = GAIN_W + ERR_W;
    localparam int I_W   = GAIN_W + INTEG_W;
    localparam int ACC_W = I_W + 3;
    localparam int CL_W  = 24;

    logic signed [PD_W-1:0]  p_prod;
    logic signed [PD_W-1:0]  d_prod;
    logic signed [I_W-1:0]   i_prod;
    logic signed [ACC_W-1:0] p_q16;
    logic signed [ACC_W-1:0] d_q16;
    logic signed [ACC_W-1:0] i_q16;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [CL_W-1:0]  clamped;
    logic signed [CL_W-1:0]  rounded;

    // Three independent products.
    assign p_prod = PD_W'(prop_gain) * PD_W'(err);
    assign d_prod = PD_W'(deriv_gain) * PD_W'(vel);
    assign i_prod = I_W'(integ_gain) * I_W'(integ_sum);

    // Sum in Q.16: P and D are Q.8 products scaled up by 8 bits.
    assign p_q16 = {{(ACC_W-PD_W-8){p_prod[PD_W-1]}}, p_prod, 8'b0};
    assign d_q16 = {{(ACC_W-PD_W-8){d_prod[PD_W-1]}}, d_prod, 8'b0};
    assign i_q16 = {{(ACC_W-I_W){i_prod[I_W-1]}}, i_prod};
    assign acc   = p_q16 + i_q16 - d_q16;

    // Clamp to the limit in Q.16.
    assign lim_pos = {{(ACC_W-LIMIT_W-16){1'b0}}, drive_limit, 16'b0};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (acc > lim_pos)
        begin
            clamped = lim_pos[CL_W-1:0];
        end
        else if (acc < lim_neg)
        begin
            clamped = lim_neg[CL_W-1:0];
        end
        else
        begin
            clamped = acc[CL_W-1:0];
        end
    end

    // Truncate toward zero: negative values are biased before the shift.
    assign rounded = clamped + (clamped[CL_W-1] ? 24'sd65535 : 24'sd0);
    assign drive   = rounded[CL_W-1:16];

endmodule

[src/pid_with_bounded_integral_core.sv]
// Top level of the bounded-integral PID core: handshakes, state registers
// and result register. Depends on pbi_pkg, pbi_cfg_regs, pbi_integ, pbi_drive.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   input    | in_valid / in_ready    | position
//   result   | out_valid / out_ready  | drive, done_res
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while out_ready stays high. An accepted word lands in
// the input register, goes through one combinational pass and moves to the result
// register, which drives the result port, once that register is free. The input
// register refills while a result waits; the block stops taking words only when both
// registers are full and out_ready is low. Reset clears the valid flags and controller
// state and restores the register defaults; config writes are registered.
module pid_with_bounded_integral_core
    import pbi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POS_W-1:0]   position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      done_res,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t       cfg;
    integ_res_t integ_res;

    logic                      in_valid_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      done_reg;
    logic                      done_next;

    logic signed [POS_W-1:0]   last_position_reg;
    logic                      first_sample_reg;
    logic signed [INTEG_W-1:0] integ_sum_reg;
    logic [COUNT_W-1:0]        band_count_reg;
    logic [COUNT_W-1:0]        band_count_next;

    logic                      load;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   vel;

    pbi_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the stored word moves to the result register when it is free.
    assign load     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || load;

    // Error against the setpoint and change since the previous reading.
    assign err = {cfg.setpoint[POS_W-1], cfg.setpoint} - {pos_reg[POS_W-1], pos_reg};
    assign vel = first_sample_reg ? '0 :
                 ({pos_reg[POS_W-1], pos_reg} -
                  {last_position_reg[POS_W-1], last_position_reg});

    pbi_integ u_integ (
        .err              (err),
        .integ_sum        (integ_sum_reg),
        .settle_band      (cfg.settle_band),
        .integ_step_limit (cfg.integ_step_limit),
        .res              (integ_res)
    );

    pbi_drive u_drive (
        .prop_gain   (cfg.prop_gain),
        .integ_gain  (cfg.integ_gain),
        .deriv_gain  (cfg.deriv_gain),
        .drive_limit (cfg.drive_limit),
        .err         (err),
        .vel         (vel),
        .integ_sum   (integ_res.integ_sum),
        .drive       (drive_next)
    );

    // Settle counter of in-band words: done fires and it clears at the step target.
    always_comb
    begin
        band_count_next = band_count_reg;
        done_next       = 1'b0;
        if (integ_res.in_band)
        begin
            if (band_count_reg >= cfg.settle_steps)
            begin
                band_count_next = '0;
                done_next       = 1'b1;
            end
            else
            begin
                band_count_next = band_count_reg + 8'd1;
            end
        end
    end

    // Valid flags and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_position_reg <= '0;
            first_sample_reg  <= 1'b1;
            integ_sum_reg     <= '0;
            band_count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (load)
            begin
                out_valid_reg     <= 1'b1;
                last_position_reg <= pos_reg;
                first_sample_reg  <= 1'b0;
                integ_sum_reg     <= integ_res.integ_sum;
                band_count_reg    <= band_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pos_reg <= position;
        end
        if (load)
        begin
            drive_reg <= drive_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign done_res  = done_reg;

endmodule

[src/pbi_checker.sv]
// Port-level checks for the bounded-integral PID core, bound to the top level.
// Depends on pbi_pkg and pid_with_bounded_integral_core.
module pbi_checker
    import pbi_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [DRIVE_W-1:0] drive,
    input logic                      done_res
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(done_res))
    else $error("result word changed while stalled");

    // The input side only stops when the result side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input not ready without a result stall");

    // Out_valid is high after an accepted word has passed the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted word produced no result");

    // Clamping and truncation never reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive != 8'sh80)
    else $error("drive outside the clamped range");

endmodule

bind pid_with_bounded_integral_core pbi_checker u_pbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .done_res  (done_res)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pid_with_bounded_integral_core: position words in,
// drive words out, checked against an in-bench model of the PID step.
// Depends on pbi_pkg and the core's RTL.
module tb_top;
    import pbi_pkg::*;

    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_WORDS   = 100;
    localparam int     WINDUP_WORDS  = 60;
    localparam int     MAX_PRINTED   = 40;
    localparam int     IDLE_PCT      = 32;
    localparam longint Q8_UNIT       = 256;
    localparam longint Q16_UNIT      = 65536;
    localparam longint POS_MAX       = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN       = -(longint'(1) <<< (POS_W - 1));
    localparam longint INTEG_MAX     = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN     = -(longint'(1) <<< (INTEG_W - 1));

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      done;
    } drive_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [POS_W-1:0]   position = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Register copy used by the drive model.
    logic signed [GAIN_W-1:0]  kp = '0;
    logic signed [GAIN_W-1:0]  ki = '0;
    logic signed [GAIN_W-1:0]  kd = '0;
    logic signed [POS_W-1:0]   target = '0;
    logic [LIMIT_W-1:0]        drive_ceiling = DRIVE_LIMIT_RST;
    logic [BAND_W-1:0]         band_width = '0;
    logic [STEP_W-1:0]         step_ceiling = STEP_LIMIT_RST;
    logic [COUNT_W-1:0]        steps_needed = SETTLE_STEPS_RST;

    // Controller state as the model sees it.
    logic signed [POS_W-1:0]   prev_position = '0;
    logic                      first_reading = 1'b1;
    logic signed [INTEG_W-1:0] integ_acc = '0;
    logic [COUNT_W-1:0]        in_band_count = '0;

    logic signed [POS_W-1:0]   position_q[$];
    drive_word_t               pending_drive_q[$];

    int send_idle_pct = IDLE_PCT;
    int recv_stall_pct = IDLE_PCT;
    int mismatches = 0;
    int words_sent = 0;
    int drives_seen = 0;
    int done_seen = 0;
    int regs_written = 0;
    int cycle_count = 0;

    pid_with_bounded_integral_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .done_res  (done_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic signed [POS_W-1:0] clip_pos(input longint v);
        if (v > POS_MAX)
            return POS_W'(POS_MAX);
        if (v < POS_MIN)
            return POS_W'(POS_MIN);
        return POS_W'(v);
    endfunction

    // Random value that lands on either end of its range about a quarter of the time.
    function automatic longint pick_value(input longint lo, input longint hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return lo;
        if (roll < 24)
            return hi;
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    // One control step: integral update, P + I - D with clamp, then the settle count.
    task automatic compute_drive(input logic signed [POS_W-1:0] pos_in);
        longint      pos, sp, bw, stepl, err, errq, sum, vel, acc, ceil16, drv;
        drive_word_t want;
        pos = pos_in;
        sp = target;
        bw = longint'(band_width);
        stepl = longint'(step_ceiling);
        if (first_reading)
        begin
            prev_position = pos_in;
            first_reading = 1'b0;
        end
        err = sp - pos;
        errq = err * Q8_UNIT;

        // The sum restarts when the error changes sign and inside the band.
        sum = integ_acc;
        if (err >= bw)
        begin
            if (sum < 0)
                sum = 0;
            sum += (errq < stepl) ? errq : stepl;
        end
        else if (err <= -bw)
        begin
            if (sum > 0)
                sum = 0;
            sum += (errq > -stepl) ? errq : -stepl;
        end
        else
            sum = 0;
        if (sum > INTEG_MAX)
            sum = INTEG_MAX;
        else if (sum < INTEG_MIN)
            sum = INTEG_MIN;
        integ_acc = INTEG_W'(sum);

        // Everything in Q.16, clamped, then truncated toward zero.
        vel = pos - longint'(prev_position);
        acc = longint'(kp) * err * Q8_UNIT + longint'(ki) * longint'(integ_acc)
            - longint'(kd) * vel * Q8_UNIT;
        ceil16 = longint'(drive_ceiling) * Q16_UNIT;
        if (acc > ceil16)
            acc = ceil16;
        else if (acc < -ceil16)
            acc = -ceil16;
        drv = (acc >= 0) ? (acc / Q16_UNIT) : -((-acc) / Q16_UNIT);
        prev_position = pos_in;

        want.drive = DRIVE_W'(drv);
        want.done = 1'b0;
        if (pos <= sp + bw && pos >= sp - bw)
        begin
            if (in_band_count >= steps_needed)
            begin
                in_band_count = '0;
                want.done = 1'b1;
            end
            else
                in_band_count = in_band_count + 1'b1;
        end
        pending_drive_q.push_back(want);
    endtask

    // Register write over the config channel; bits above the field are random.
    task automatic write_reg(input cfg_index_t idx, input longint v);
        int unsigned           w;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        case (idx)
            REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN: w = GAIN_W;
            REG_SETPOINT:    w = POS_W;
            REG_DRIVE_LIMIT: w = LIMIT_W;
            REG_SETTLE_BAND: w = BAND_W;
            REG_STEP_LIMIT:  w = STEP_W;
            default:         w = COUNT_W;
        endcase
        mask = (CFG_DATA_W'(1) << w) - 1'b1;
        data = (CFG_DATA_W'($urandom()) & ~mask) | (CFG_DATA_W'(v) & mask);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:   kp = data[GAIN_W-1:0];
            REG_INTEG_GAIN:  ki = data[GAIN_W-1:0];
            REG_DERIV_GAIN:  kd = data[GAIN_W-1:0];
            REG_SETPOINT:    target = data[POS_W-1:0];
            REG_DRIVE_LIMIT: drive_ceiling = data[LIMIT_W-1:0];
            REG_SETTLE_BAND: band_width = data[BAND_W-1:0];
            REG_STEP_LIMIT:  step_ceiling = data[STEP_W-1:0];
            default:         steps_needed = data[COUNT_W-1:0];
        endcase
        regs_written++;
    endtask

    task automatic write_all_regs(input longint p, input longint i, input longint d,
                                  input longint sp, input longint lim, input longint bw,
                                  input longint stepl, input longint steps);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_DRIVE_LIMIT, lim);
        write_reg(REG_SETTLE_BAND, bw);
        write_reg(REG_STEP_LIMIT, stepl);
        write_reg(REG_SETTLE_STEPS, steps);
    endtask

    // Gains are mostly moderate so the drive is not always pinned at the clamp.
    function automatic longint pick_gain();
        if ($urandom_range(1))
            return pick_value(-1024, 1024);
        return pick_value(-32768, 32767);
    endfunction

    // New random settings; after the first phase each register changes with odds of 3 in 4.
    task automatic setup_random_phase(input bit write_all);
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_PROP_GAIN, pick_gain());
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_INTEG_GAIN, pick_gain());
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_DERIV_GAIN, pick_gain());
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_SETPOINT, $urandom_range(1) ? pick_value(-5000, 5000)
                                                      : pick_value(POS_MIN, POS_MAX));
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_DRIVE_LIMIT, pick_value(0, 127));
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_SETTLE_BAND, ($urandom_range(99) < 60) ? pick_value(0, 40)
                                                                 : pick_value(0, 65535));
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_STEP_LIMIT, pick_value(0, 65535));
        if (write_all || $urandom_range(3) != 0)
            write_reg(REG_SETTLE_STEPS, ($urandom_range(99) < 70) ? pick_value(0, 12)
                                                                  : pick_value(0, 255));
    endtask

    // Mostly settling runs that close in on the target, plus noise and band edges.
    task automatic queue_random_words(input int count);
        longint off, sp, bw;
        int     n, len, kind;
        sp = target;
        bw = longint'(band_width);
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                off = longint'($urandom_range(32'(4 * bw + 2000)));
                if ($urandom_range(1))
                    off = -off;
                len = $urandom_range(30, 4);
                repeat (len)
                begin
                    position_q.push_back(clip_pos(sp + off));
                    off = off * 3 / 4 + longint'($urandom_range(4)) - 2;
                    n++;
                end
            end
            else if (kind < 85)
            begin
                position_q.push_back(POS_W'($urandom()));
                n++;
            end
            else
            begin
                case ($urandom_range(3))
                    0:       off = bw;
                    1:       off = -bw;
                    2:       off = bw + 1;
                    default: off = -bw - 1;
                endcase
                position_q.push_back(clip_pos(sp + off));
                n++;
            end
        end
    endtask

    // Hold off until every queued word has gone through and every drive has come back.
    task automatic wait_drained();
        while (position_q.size() != 0 || in_valid || pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sender: predict on acceptance, then offer the next word or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                compute_drive(position);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (position_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    position <= position_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: compare each accepted drive word with the oldest prediction.
    always @(posedge clk)
    begin : drive_monitor
        drive_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                drives_seen++;
                if (pending_drive_q.size() == 0)
                    note_mismatch($sformatf("drive %0d done %0d with no word outstanding",
                                            drive, done_res));
                else
                begin
                    want = pending_drive_q.pop_front();
                    if (drive !== want.drive)
                        note_mismatch($sformatf("drive word %0d: drive %0d, model %0d",
                                                drives_seen, drive, want.drive));
                    if (done_res !== want.done)
                        note_mismatch($sformatf("drive word %0d: done %0b, model %0b",
                                                drives_seen, done_res, want.done));
                    if (want.done)
                        done_seen++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d drive words outstanding",
                     cycle_count, pending_drive_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        // First samples with zero D, extreme positions, band edges on both sides.
        longint near_target[12] = '{1000, 1000, 1000, 1000, POS_MAX, POS_MIN,
                                    1005, 995, 1006, 994, 2000, 2000};
        // Zero band: an exact hit takes the positive branch and clears a negative sum.
        longint zero_band[6] = '{POS_MIN, POS_MIN + 8, POS_MIN, POS_MAX, POS_MIN,
                                 POS_MIN + 1};
        // Drive ceiling of zero with the widest band and no integral step.
        longint zero_ceiling[3] = '{0, POS_MAX, POS_MIN};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_all_regs(256, 64, -32768, 1000, 100, 5, 300, 2);
        foreach (near_target[i])
            position_q.push_back(clip_pos(near_target[i]));
        wait_drained();

        write_all_regs(-32768, 32767, 32767, POS_MIN, 127, 0, 65535, 0);
        foreach (zero_band[i])
            position_q.push_back(clip_pos(zero_band[i]));
        wait_drained();

        write_all_regs(32767, -32768, 0, POS_MAX, 0, 65535, 0, 255);
        foreach (zero_ceiling[i])
            position_q.push_back(clip_pos(zero_ceiling[i]));
        wait_drained();

        // Random settings; one phase runs with neither side idling.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            send_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            recv_stall_pct = (p == 3) ? 0 : IDLE_PCT;
            setup_random_phase(p == 0);
            queue_random_words(PHASE_WORDS);
            wait_drained();
        end

        // Long one-sided error winds the integral up, then the other way.
        write_all_regs(pick_gain(), pick_gain(), pick_gain(), 0, pick_value(0, 127), 0,
                       65535, pick_value(0, 255));
        repeat (WINDUP_WORDS)
            position_q.push_back(clip_pos(-longint'($urandom_range(32'(-POS_MIN), 256))));
        repeat (WINDUP_WORDS)
            position_q.push_back(clip_pos(longint'($urandom_range(32'(POS_MAX), 256))));
        wait_drained();

        $display("sent %0d position words, checked %0d drive words, %0d with done set",
                 words_sent, drives_seen, done_seen);
        $display("%0d register writes over 3 directed, %0d random and 1 windup phase",
                 regs_written, RANDOM_PHASES);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[pid_with_bounded_integral_core.f]
src/pbi_pkg.sv
src/pbi_cfg_regs.sv
src/pbi_integ.sv
src/pbi_drive.sv
src/pid_with_bounded_integral_core.sv
src/pbi_checker.sv
tb/tb_top.sv
